### sv/lacb_pkg.sv
package lacb_pkg;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] right_z;
        logic signed [31:0] down_x;
        logic signed [31:0] down_y;
        logic signed [31:0] down_z;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic signed [31:0] corner_z;
        logic               degenerate;
    } out_t;

    typedef logic [2:0][63:0] vec64_t;
    typedef logic [2:0][31:0] vec32_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FOCAL  = 2'd2
    } cfg_idx_t;

    localparam logic [15:0] WIDTH_RST  = 16'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;
    localparam logic [30:0] FOCAL_RST  = 31'd20971520;

    localparam int SHIFT_RIGHT_STEPS = 6;
    localparam int SHIFT_STEPS       = 11;
    localparam int SQRT_STEPS        = 31;
    localparam int DIV_STEPS         = 31;
    localparam int NORM_LAT   = 1 + SHIFT_STEPS + 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int CROSS_LAT  = 2;
    localparam int CORNER_LAT = 3;

    // right steps 32,16,8,4,2,1 then left steps 16,8,4,2,1
    function automatic int shift_amt(input int k);
        int s;
        if (k < SHIFT_RIGHT_STEPS)
            s = 32 >> k;
        else
            s = 16 >> (k - SHIFT_RIGHT_STEPS);
        return s;
    endfunction

endpackage

### sv/lacb_dly.sv
module lacb_dly #(
    parameter int W     = 32,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
                line_reg[k] <= line_reg[k-1];
        end
    end

    assign dout = line_reg[DEPTH-1];
endmodule

### sv/lacb_cross.sv
module lacb_cross (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vin,
    input  lacb_pkg::vec32_t a,
    input  lacb_pkg::vec32_t b,
    output logic            vout,
    output lacb_pkg::vec64_t r
);
    import lacb_pkg::*;

    logic signed [63:0] p_reg [6];
    logic [1:0]         v_reg;
    vec64_t             r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[0], vin};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= $signed(a[1]) * $signed(b[2]);
            p_reg[1] <= $signed(a[2]) * $signed(b[1]);
            p_reg[2] <= $signed(a[2]) * $signed(b[0]);
            p_reg[3] <= $signed(a[0]) * $signed(b[2]);
            p_reg[4] <= $signed(a[0]) * $signed(b[1]);
            p_reg[5] <= $signed(a[1]) * $signed(b[0]);
            r_reg[0] <= p_reg[0] - p_reg[1];
            r_reg[1] <= p_reg[2] - p_reg[3];
            r_reg[2] <= p_reg[4] - p_reg[5];
        end
    end

    assign vout = v_reg[1];
    assign r    = r_reg;
endmodule

### sv/lacb_norm.sv
module lacb_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vin,
    input  lacb_pkg::vec64_t v,
    output logic             vout,
    output lacb_pkg::vec32_t u
);
    import lacb_pkg::*;

    logic [NORM_LAT-1:0] v_reg;
    logic [3:0]          side_reg   [NORM_LAT-1];
    logic [2:0][63:0]    sh_mag_reg [SHIFT_STEPS+1];
    logic [63:0]         sh_m_reg   [SHIFT_STEPS+1];
    logic [59:0]         sq_reg     [3];
    logic [2:0][29:0]    mg_reg     [SQRT_STEPS+2];
    logic [61:0]         sx_reg     [SQRT_STEPS+1];
    logic [61:0]         sr_reg     [SQRT_STEPS+1];
    logic [2:0][60:0]    dn_reg     [DIV_STEPS+1];
    logic [30:0]         dl_reg     [DIV_STEPS+1];
    logic [2:0][30:0]    q_reg      [DIV_STEPS+1];
    vec32_t              u_reg;
    logic [2:0][63:0]    mag;
    logic [63:0]         m;
    logic [30:0]         len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NORM_LAT-2:0], vin};
    end

    // magnitudes and their maximum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag[i] = v[i][63] ? (~v[i] + 64'd1) : v[i];
        m = mag[0];
        if (mag[1] > m)
            m = mag[1];
        if (mag[2] > m)
            m = mag[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_mag_reg[0] <= mag;
            sh_m_reg[0]   <= m;
            side_reg[0]   <= {m == 64'd0, v[2][63], v[1][63], v[0][63]};
            for (int k = 1; k < NORM_LAT - 1; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // bring the largest magnitude into [2^29, 2^30)
    for (genvar k = 0; k < SHIFT_STEPS; k++)
    begin : g_shift
        localparam int          S     = shift_amt(k);
        localparam bit          RIGHT = (k < SHIFT_RIGHT_STEPS);
        localparam logic [63:0] TH    = RIGHT ? (64'd1 << (29 + S)) : (64'd1 << (30 - S));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (RIGHT && sh_m_reg[k] >= TH)
                begin
                    for (int i = 0; i < 3; i++)
                        sh_mag_reg[k+1][i] <= sh_mag_reg[k][i] >> S;
                    sh_m_reg[k+1] <= sh_m_reg[k] >> S;
                end
                else if (!RIGHT && sh_m_reg[k] < TH)
                begin
                    for (int i = 0; i < 3; i++)
                        sh_mag_reg[k+1][i] <= sh_mag_reg[k][i] << S;
                    sh_m_reg[k+1] <= sh_m_reg[k] << S;
                end
                else
                begin
                    sh_mag_reg[k+1] <= sh_mag_reg[k];
                    sh_m_reg[k+1]   <= sh_m_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]    <= sh_mag_reg[SHIFT_STEPS][i][29:0]
                              * sh_mag_reg[SHIFT_STEPS][i][29:0];
                mg_reg[0][i] <= sh_mag_reg[SHIFT_STEPS][i][29:0];
            end
            sx_reg[0] <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
            sr_reg[0] <= '0;
            mg_reg[1] <= mg_reg[0];
        end
    end

    // square root, one result bit a stage
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [61:0] B = 62'd1 << (2 * (SQRT_STEPS - 1 - j));
        logic [62:0] trial;

        assign trial = {1'b0, sr_reg[j]} + {1'b0, B};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, sx_reg[j]} >= trial)
                begin
                    sx_reg[j+1] <= sx_reg[j] - trial[61:0];
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + B;
                end
                else
                begin
                    sx_reg[j+1] <= sx_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
                mg_reg[j+2] <= mg_reg[j+1];
            end
        end
    end

    assign len = sr_reg[SQRT_STEPS][30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                dn_reg[0][i] <= {1'b0, mg_reg[SQRT_STEPS+1][i], 30'd0} + {31'd0, len[30:1]};
            dl_reg[0] <= len;
            q_reg[0]  <= '0;
        end
    end

    // restoring division, one quotient bit a stage, three lanes
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int          I    = DIV_STEPS - 1 - j;
        localparam logic [30:0] QBIT = 31'd1 << I;
        logic [60:0] dv;

        assign dv = {30'd0, dl_reg[j]} << I;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dn_reg[j][i] >= dv)
                    begin
                        dn_reg[j+1][i] <= dn_reg[j][i] - dv;
                        q_reg[j+1][i]  <= q_reg[j][i] | QBIT;
                    end
                    else
                    begin
                        dn_reg[j+1][i] <= dn_reg[j][i];
                        q_reg[j+1][i]  <= q_reg[j][i];
                    end
                end
                dl_reg[j+1] <= dl_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (side_reg[NORM_LAT-2][3])
                    u_reg[i] <= '0;
                else if (side_reg[NORM_LAT-2][i])
                    u_reg[i] <= -{1'b0, q_reg[DIV_STEPS][i]};
                else
                    u_reg[i] <= {1'b0, q_reg[DIV_STEPS][i]};
            end
        end
    end

    assign vout = v_reg[NORM_LAT-1];
    assign u    = u_reg;
endmodule

### sv/lacb_corner.sv
module lacb_corner (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vin,
    input  lacb_pkg::vec32_t vd,
    input  lacb_pkg::vec32_t rt,
    input  lacb_pkg::vec32_t dn,
    input  logic [15:0]      image_width,
    input  logic [15:0]      image_height,
    input  logic [30:0]      focal_distance,
    output logic             vout,
    output lacb_pkg::out_t   res
);
    import lacb_pkg::*;

    logic [CORNER_LAT-1:0] v_reg;
    logic signed [63:0]    pf_reg  [3];
    logic signed [63:0]    pw_reg  [3];
    logic signed [63:0]    ph_reg  [3];
    logic signed [63:0]    acc_reg [3];
    vec32_t                rt_reg  [2];
    vec32_t                dn_reg  [2];
    logic [1:0]            deg_reg;
    out_t                  res_reg;
    logic signed [32:0]    hw;
    logic signed [32:0]    hh;
    logic signed [31:0]    f;
    logic signed [64:0]    t    [3];
    logic [31:0]           sat  [3];

    assign hw = $signed({2'b00, image_width, 15'd0});
    assign hh = $signed({2'b00, image_height, 15'd0});
    assign f  = $signed({1'b0, focal_distance});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[CORNER_LAT-2:0], vin};
    end

    // round to Q16.16 and saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t[i] = {acc_reg[i][63], acc_reg[i]} + 65'sd536870912;
            if (t[i][64:61] != {4{t[i][61]}})
                sat[i] = t[i][64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                sat[i] = t[i][61:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pf_reg[i]  <= $signed(vd[i]) * f;
                pw_reg[i]  <= $signed(rt[i]) * hw;
                ph_reg[i]  <= $signed(dn[i]) * hh;
                acc_reg[i] <= pf_reg[i] - pw_reg[i] - ph_reg[i];
            end
            rt_reg[0]  <= rt;
            dn_reg[0]  <= dn;
            rt_reg[1]  <= rt_reg[0];
            dn_reg[1]  <= dn_reg[0];
            // a unit vector is never all zero
            deg_reg[0] <= (dn == '0);
            deg_reg[1] <= deg_reg[0];
            if (deg_reg[1])
            begin
                res_reg.right_x    <= '0;
                res_reg.right_y    <= '0;
                res_reg.right_z    <= '0;
                res_reg.down_x     <= '0;
                res_reg.down_y     <= '0;
                res_reg.down_z     <= '0;
                res_reg.corner_x   <= '0;
                res_reg.corner_y   <= '0;
                res_reg.corner_z   <= '0;
                res_reg.degenerate <= 1'b1;
            end
            else
            begin
                res_reg.right_x    <= rt_reg[1][0];
                res_reg.right_y    <= rt_reg[1][1];
                res_reg.right_z    <= rt_reg[1][2];
                res_reg.down_x     <= dn_reg[1][0];
                res_reg.down_y     <= dn_reg[1][1];
                res_reg.down_z     <= dn_reg[1][2];
                res_reg.corner_x   <= sat[0];
                res_reg.corner_y   <= sat[1];
                res_reg.corner_z   <= sat[2];
                res_reg.degenerate <= 1'b0;
            end
        end
    end

    assign vout = v_reg[CORNER_LAT-1];
    assign res  = res_reg;
endmodule

### sv/look_at_camera_basis.sv
// Look-at camera basis. One pose (eye, target, up, Q16.16) is taken per
// transaction and gives one result: unit right and down axes in Q2.30 and the
// top-left corner vector in Q16.16. The pipeline accepts a transaction every
// cycle while the output is not stalled; acceptance lands the pose in the
// input register, then a difference stage, three normalisers of 78 stages
// each (the depth is set by the 31-stage square root and the 31-stage divider
// in each), two 2-stage cross products and a 3-stage corner unit ending in the
// output register.
// A stalled output holds the whole pipeline; the input register still takes
// one transaction while it is empty. Configuration writes (index 0 width,
// 1 height, 2 focal distance) are always ready and must only be made while
// no transaction is in flight.
module look_at_camera_basis (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lacb_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output lacb_pkg::out_t  out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import lacb_pkg::*;

    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [30:0] focal_reg;
    in_t         hold_reg;
    logic        hold_v_reg;
    vec64_t      d_reg;
    vec32_t      up_reg;
    logic        d_v_reg;
    logic        en;
    vec32_t      up_d;
    vec32_t      vd;
    vec32_t      vd_d1;
    vec32_t      vd_d2;
    vec32_t      rt;
    vec32_t      rt_d;
    vec32_t      dn;
    vec64_t      t1;
    vec64_t      t2;
    logic        vd_v;
    logic        t1_v;
    logic        rt_v;
    logic        t2_v;
    logic        dn_v;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = !hold_v_reg || en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            focal_reg  <= FOCAL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[15:0];
                CFG_HEIGHT: height_reg <= cfg_data[15:0];
                CFG_FOCAL:  focal_reg  <= cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            d_v_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
                hold_v_reg <= in_valid;
            if (en)
                d_v_reg <= hold_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            hold_reg <= in_data;
        if (en)
        begin
            d_reg[0] <= {{32{hold_reg.target_x[31]}}, hold_reg.target_x}
                      - {{32{hold_reg.eye_x[31]}}, hold_reg.eye_x};
            d_reg[1] <= {{32{hold_reg.target_y[31]}}, hold_reg.target_y}
                      - {{32{hold_reg.eye_y[31]}}, hold_reg.eye_y};
            d_reg[2] <= {{32{hold_reg.target_z[31]}}, hold_reg.target_z}
                      - {{32{hold_reg.eye_z[31]}}, hold_reg.eye_z};
            up_reg   <= {hold_reg.up_z, hold_reg.up_y, hold_reg.up_x};
        end
    end

    lacb_norm u_norm_view (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (d_v_reg),
        .v    (d_reg),
        .vout (vd_v),
        .u    (vd)
    );

    lacb_dly #(.W(96), .DEPTH(NORM_LAT)) u_dly_up (
        .clk (clk),
        .en  (en),
        .din (up_reg),
        .dout(up_d)
    );

    lacb_cross u_cross_right (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (vd_v),
        .a    (vd),
        .b    (up_d),
        .vout (t1_v),
        .r    (t1)
    );

    lacb_norm u_norm_right (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (t1_v),
        .v    (t1),
        .vout (rt_v),
        .u    (rt)
    );

    lacb_dly #(.W(96), .DEPTH(CROSS_LAT + NORM_LAT)) u_dly_vd1 (
        .clk (clk),
        .en  (en),
        .din (vd),
        .dout(vd_d1)
    );

    lacb_cross u_cross_down (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (rt_v),
        .a    (vd_d1),
        .b    (rt),
        .vout (t2_v),
        .r    (t2)
    );

    lacb_norm u_norm_down (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (t2_v),
        .v    (t2),
        .vout (dn_v),
        .u    (dn)
    );

    lacb_dly #(.W(96), .DEPTH(CROSS_LAT + NORM_LAT)) u_dly_rt (
        .clk (clk),
        .en  (en),
        .din (rt),
        .dout(rt_d)
    );

    lacb_dly #(.W(96), .DEPTH(CROSS_LAT + NORM_LAT)) u_dly_vd2 (
        .clk (clk),
        .en  (en),
        .din (vd_d1),
        .dout(vd_d2)
    );

    lacb_corner u_corner (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .vin           (dn_v),
        .vd            (vd_d2),
        .rt            (rt_d),
        .dn            (dn),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .focal_distance(focal_reg),
        .vout          (out_valid),
        .res           (out_data)
    );

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.right_x == 0 && out_data.down_x == 0 && out_data.corner_x == 0
            && out_data.corner_y == 0 && out_data.corner_z == 0)
        else $error("degenerate result carries non-zero fields");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.degenerate |->
            out_data.right_x <= 32'sd1073741824 && out_data.right_x >= -32'sd1073741824
            && out_data.down_z <= 32'sd1073741824 && out_data.down_z >= -32'sd1073741824)
        else $error("axis component outside unit range");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        hold_v_reg && !en |=> hold_v_reg && $stable(hold_reg))
        else $error("input register lost a transaction during a stall");

endmodule
